@@ design/tts_pkg.sv @@
// Package for the tactile taxel scan sequencer.
// Holds the widths, the taxel map ROM, the config register indexes and the
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package tts_pkg;

	// Sizes
	localparam int NUM_TAXELS = 12;
	localparam int TAXEL_W    = 4;
	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 20;
	localparam int COUNT_W    = 5;
	localparam int SPR_W      = 5;
	localparam int DISC_W     = 3;
	localparam int SEL_W      = 3;
	localparam int CFG_W      = 5;
	localparam int DIV_STEP_W = $clog2(SUM_W);

	// Averaging count limits
	localparam logic [SPR_W-1:0] SPR_MIN = SPR_W'(1);
	localparam logic [SPR_W-1:0] SPR_MAX = SPR_W'(16);

	// Config register indexes
	localparam logic CFG_SPR     = 1'b0;
	localparam logic CFG_DISCARD = 1'b1;

	// Result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FRAME  = 1'b1;

	// ADC command base word
	localparam logic [15:0] ADC_CMD_BASE = 16'h3c09;

	typedef struct packed {
		logic             chan;
		logic [SEL_W-1:0] mux0;
		logic [SEL_W-1:0] mux1;
		logic [SEL_W-1:0] led;
	} taxel_entry_t;

	// Taxel map ROM
	function automatic taxel_entry_t taxel_rom(input logic [TAXEL_W-1:0] idx);
		taxel_entry_t e;
		case (idx)
			4'd0:    e = '{1'b0, 3'd3, 3'd0, 3'd0};
			4'd1:    e = '{1'b1, 3'd3, 3'd5, 3'd0};
			4'd2:    e = '{1'b0, 3'd7, 3'd5, 3'd1};
			4'd3:    e = '{1'b0, 3'd6, 3'd5, 3'd1};
			4'd4:    e = '{1'b0, 3'd0, 3'd3, 3'd2};
			4'd5:    e = '{1'b1, 3'd0, 3'd3, 3'd2};
			4'd6:    e = '{1'b0, 3'd1, 3'd3, 3'd3};
			4'd7:    e = '{1'b1, 3'd1, 3'd6, 3'd3};
			4'd8:    e = '{1'b1, 3'd1, 3'd0, 3'd4};
			4'd9:    e = '{1'b1, 3'd1, 3'd1, 3'd4};
			4'd10:   e = '{1'b1, 3'd1, 3'd4, 3'd5};
			4'd11:   e = '{1'b0, 3'd2, 3'd4, 3'd5};
			default: e = '{1'b0, 3'd0, 3'd0, 3'd0};
		endcase
		return e;
	endfunction

	// ADC command word for a channel
	function automatic logic [15:0] adc_cmd(input logic chan);
		return 16'((ADC_CMD_BASE | (16'(chan) << 7)) << 2);
	endfunction

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_STATUS,
		ST_FRAME
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic sample;
		logic div_start;
		logic commit;
		logic load_status;
		logic load_frame;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic complete;
		logic div_done;
		logic wrap;
		logic slot_free;
		logic frame_last;
	} dp_status_t;

endpackage

@@ design/tts_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Divides the saturated sample sum by the averaging count. Uses tts_pkg.
`timescale 1ns / 1ps

module tts_div
	import tts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [SPR_W-1:0] divisor,
	output logic             done,
	output logic [SUM_W-1:0] quotient
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [SUM_W-1:0]      work_q;
	logic [SPR_W-1:0]      rem_q;
	logic [SPR_W-1:0]      dvs_q;

	logic [SPR_W:0]        trial;
	logic [SPR_W:0]        diff;
	logic                  ge;

	// One trial subtraction
	always_comb begin
		trial = {rem_q, work_q[SUM_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + DIV_STEP_W'(1);
				if (step_q == DIV_STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[SUM_W-2:0], ge};
			rem_q  <= ge ? diff[SPR_W-1:0] : trial[SPR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

@@ design/tts_dp.sv @@
// Datapath: config registers, sample accumulator, taxel pointer, frame
// store and result register. Uses tts_pkg and tts_div.
`timescale 1ns / 1ps

module tts_dp
	import tts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic [SAMPLE_W-1:0] adc_word,
	input  ctrl_cmd_t           cmd,
	output dp_status_t          sts,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                kind,
	output logic [TAXEL_W-1:0]  taxel_index,
	output logic [SAMPLE_W-1:0] reading,
	output logic                reading_done,
	output logic [15:0]         adc_command,
	output logic [SEL_W-1:0]    mux0_select,
	output logic [SEL_W-1:0]    mux1_select,
	output logic [SEL_W-1:0]    led_select,
	output logic                last
);

	logic [SPR_W-1:0]    spr_q;
	logic [DISC_W-1:0]   discard_q;
	logic [COUNT_W-1:0]  count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [TAXEL_W-1:0]  active_q;
	logic [TAXEL_W-1:0]  frame_idx_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic                done_flag_q;
	logic                wrap_q;
	logic [SAMPLE_W-1:0] store_q [NUM_TAXELS];
	logic                out_valid_q;

	logic [SPR_W-1:0]    spr_eff;
	logic                in_discard;
	logic [COUNT_W-1:0]  count_inc;
	logic [SUM_W:0]      sum_add;
	logic [SUM_W-1:0]    sum_sat;
	logic [COUNT_W:0]    target;
	logic                div_done;
	logic [SUM_W-1:0]    quotient;
	logic [SAMPLE_W-1:0] avg_sat;
	logic                slot_free;
	taxel_entry_t        entry;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q     <= SPR_W'(10);
			discard_q <= DISC_W'(3);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SPR:     spr_q     <= cfg_data[SPR_W-1:0];
				CFG_DISCARD: discard_q <= cfg_data[DISC_W-1:0];
				default:     spr_q     <= spr_q;
			endcase
		end
	end

	// Accumulate step and completion test
	always_comb begin
		if (spr_q < SPR_MIN)
			spr_eff = SPR_MIN;
		else if (spr_q > SPR_MAX)
			spr_eff = SPR_MAX;
		else
			spr_eff = spr_q;
		in_discard = count_q < COUNT_W'(discard_q);
		count_inc  = (count_q != '1) ? count_q + COUNT_W'(1) : count_q;
		sum_add    = {1'b0, sum_q} + (SUM_W+1)'(adc_word);
		sum_sat    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
		target     = (COUNT_W+1)'(discard_q) + (COUNT_W+1)'(spr_eff);
	end

	assign avg_sat = (quotient[SUM_W-1:SAMPLE_W] != '0) ? '1 : quotient[SAMPLE_W-1:0];

	tts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_sat),
		.divisor  (spr_eff),
		.done     (div_done),
		.quotient (quotient)
	);

	// Reading state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_q       <= '0;
			active_q    <= '0;
			done_flag_q <= 1'b0;
			wrap_q      <= 1'b0;
		end else if (cmd.sample) begin
			done_flag_q <= 1'b0;
			wrap_q      <= 1'b0;
			if (in_discard) begin
				count_q <= count_q + COUNT_W'(1);
			end else begin
				sum_q   <= sum_sat;
				count_q <= count_inc;
			end
		end else if (cmd.commit) begin
			done_flag_q <= 1'b1;
			count_q     <= '0;
			sum_q       <= '0;
			if (active_q >= TAXEL_W'(NUM_TAXELS - 1)) begin
				active_q <= '0;
				wrap_q   <= 1'b1;
			end else begin
				active_q <= active_q + TAXEL_W'(1);
			end
		end
	end

	// Average and frame store
	always_ff @(posedge clk) begin
		if (cmd.sample)
			avg_q <= '0;
		else if (cmd.commit) begin
			avg_q             <= avg_sat;
			store_q[active_q] <= avg_sat;
		end
	end

	// Frame readout pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			frame_idx_q <= '0;
		else if (cmd.load_status)
			frame_idx_q <= '0;
		else if (cmd.load_frame)
			frame_idx_q <= frame_idx_q + TAXEL_W'(1);
	end

	// Result register
	assign slot_free = !out_valid_q || !out_stall;
	assign entry     = taxel_rom(active_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_status || cmd.load_frame)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_status) begin
			kind         <= KIND_STATUS;
			taxel_index  <= active_q;
			reading      <= avg_q;
			reading_done <= done_flag_q;
			adc_command  <= adc_cmd(entry.chan);
			mux0_select  <= entry.mux0;
			mux1_select  <= entry.mux1;
			led_select   <= entry.led;
			last         <= !wrap_q;
		end else if (cmd.load_frame) begin
			kind         <= KIND_FRAME;
			taxel_index  <= frame_idx_q;
			reading      <= store_q[frame_idx_q];
			reading_done <= 1'b0;
			adc_command  <= '0;
			mux0_select  <= '0;
			mux1_select  <= '0;
			led_select   <= '0;
			last         <= sts.frame_last;
		end
	end

	assign out_valid = out_valid_q;

	// Status to controller
	always_comb begin
		sts.complete   = !in_discard && ({1'b0, count_inc} >= target);
		sts.div_done   = div_done;
		sts.wrap       = wrap_q;
		sts.slot_free  = slot_free;
		sts.frame_last = frame_idx_q == TAXEL_W'(NUM_TAXELS - 1);
	end

endmodule

@@ design/tts_ctrl.sv @@
// Controller state machine: sample intake, divide wait, status result and
// frame readout sequencing. Uses tts_pkg.
`timescale 1ns / 1ps

module tts_ctrl
	import tts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t sts,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.sample = 1'b1;
					if (sts.complete) begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIVIDE;
					end else begin
						state_d = ST_STATUS;
					end
				end
			end
			ST_DIVIDE: begin
				if (sts.div_done) begin
					cmd.commit = 1'b1;
					state_d    = ST_STATUS;
				end
			end
			ST_STATUS: begin
				if (sts.slot_free) begin
					cmd.load_status = 1'b1;
					state_d         = sts.wrap ? ST_FRAME : ST_IDLE;
				end
			end
			ST_FRAME: begin
				if (sts.slot_free) begin
					cmd.load_frame = 1'b1;
					if (sts.frame_last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ design/tactile_taxel_scan_sequencer.sv @@
// Tactile taxel scan sequencer: round-robin taxel averaging and frame output.
// Top level; uses tts_pkg, tts_ctrl and tts_dp (which holds tts_div).
//
// Usage:
//  - Input channel (in_valid/in_stall, adc_word): one ADC sample per item.
//  - Output channel (out_valid/out_stall): a drive/status item for every
//    sample (kind 0), followed by NUM_TAXELS frame items (kind 1) when the
//    sample finishes the last taxel. last marks the final item of a sample.
//  - Config port (cfg_we, cfg_index, cfg_data): index 0 samples_per_reading,
//    index 1 discard_count; user writes only while block is idle (unchecked).
// Timing:
//  - A sample that does not finish a reading: the status state loads the status
//    item once the result register is free, then the next sample can be taken.
//  - A finishing sample runs the 20-step serial divider; the average is then
//    committed and the status item loaded. A frame adds one item per cycle
//    (12) unless out_stall holds it. Throughput is set by the serial divider
//    and the single result register; the block handles one sample at a time.
// Reset: taxel 0, empty accumulator, config at 10 and 3. Frame store entries
//  are filled in taxel order during the first scan.
// Stall: the result register holds while out_stall is high; a new sample may
//  still be accepted and waits for the register to free up.
`timescale 1ns / 1ps

module tactile_taxel_scan_sequencer
	import tts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] adc_word,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                kind,
	output logic [TAXEL_W-1:0]  taxel_index,
	output logic [SAMPLE_W-1:0] reading,
	output logic                reading_done,
	output logic [15:0]         adc_command,
	output logic [SEL_W-1:0]    mux0_select,
	output logic [SEL_W-1:0]    mux1_select,
	output logic [SEL_W-1:0]    led_select,
	output logic                last
);

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	tts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tts_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.adc_word     (adc_word),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.taxel_index  (taxel_index),
		.reading      (reading),
		.reading_done (reading_done),
		.adc_command  (adc_command),
		.mux0_select  (mux0_select),
		.mux1_select  (mux1_select),
		.led_select   (led_select),
		.last         (last)
	);

endmodule
